@@ sv/wrss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrss_pkg
// Shared types, constants and lookup functions for the weighted radio slot
// scheduler: phase and radio codes, the profile weight table, config layout.
// ----------------------------------------------------------------------------
package wrss_pkg;

    // Slot and profile geometry
    localparam int NUM_SLOTS    = 4;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int NUM_PROFILES = 8;
    localparam int PROF_W       = 3;
    localparam int WEIGHT_W     = 7;
    localparam int MSPW_W       = 7;
    localparam int MS_W         = 14;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 14;

    // Slots that belong to the Wi-Fi, BLE and 802.15.4 radios
    localparam logic [SLOT_W-1:0] SLOT_WIFI = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_BLE  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_154  = SLOT_W'(2);

    // Scheduler phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_AWAIT = 2'd1;
    localparam logic [1:0] PH_DWELL = 2'd2;
    localparam logic [1:0] PH_PAUSE = 2'd3;

    // Radio target codes
    localparam logic [1:0] TGT_IDLE = 2'd0;
    localparam logic [1:0] TGT_WIFI = 2'd1;
    localparam logic [1:0] TGT_BLE  = 2'd2;
    localparam logic [1:0] TGT_154  = 2'd3;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_154   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_PAUSE = 3'd4;

    // Config reset values
    localparam logic [PROF_W-1:0] RST_PROFILE    = '0;
    localparam logic              RST_HAS_154    = 1'b1;
    localparam logic [MSPW_W-1:0] RST_MS_PER_W   = 7'd100;
    localparam logic [MS_W-1:0]   RST_MIN_DWELL  = 14'd500;
    localparam logic [MS_W-1:0]   RST_FAIL_PAUSE = 14'd200;

    typedef logic [WEIGHT_W-1:0] t_weight;

    // Profile weight table, one row per profile, one column per slot
    localparam t_weight WEIGHT_TABLE [NUM_PROFILES][NUM_SLOTS] = '{
        '{7'd30, 7'd30, 7'd30, 7'd10},
        '{7'd70, 7'd20, 7'd0,  7'd10},
        '{7'd20, 7'd70, 7'd0,  7'd10},
        '{7'd20, 7'd10, 7'd70, 7'd0 },
        '{7'd30, 7'd20, 7'd0,  7'd50},
        '{7'd20, 7'd70, 7'd0,  7'd10},
        '{7'd10, 7'd5,  7'd80, 7'd5 },
        '{7'd10, 7'd10, 7'd75, 7'd5 }
    };

    typedef struct packed {
        logic [PROF_W-1:0] profile;
        logic              has_154_radio;
        logic [MSPW_W-1:0] ms_per_weight;
        logic [MS_W-1:0]   min_dwell_ms;
        logic [MS_W-1:0]   fail_pause_ms;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic start_request;
        logic stop_request;
        logic switch_done;
        logic switch_ok;
    } t_item;

    typedef struct packed {
        logic              survey_active;
        logic [SLOT_W-1:0] current_slot;
        logic              radio_request_valid;
        logic [1:0]        radio_target;
        logic              start_refused;
        logic [1:0]        phase;
    } t_result;

    // Profile index lies within the table
    function automatic logic profile_ok(input logic [PROF_W-1:0] prof);
        profile_ok = (int'(prof) < NUM_PROFILES);
    endfunction

    // Weight of a slot under a profile; zero for a profile beyond the table
    function automatic t_weight weight_of(input logic [PROF_W-1:0] prof,
                                          input logic [SLOT_W-1:0] slot);
        if (profile_ok(prof)) begin
            weight_of = WEIGHT_TABLE[prof][slot];
        end else begin
            weight_of = '0;
        end
    endfunction

    // Radio that serves a slot
    function automatic logic [1:0] target_of(input logic [SLOT_W-1:0] slot);
        if (slot == SLOT_BLE) begin
            target_of = TGT_BLE;
        end else if (slot == SLOT_154) begin
            target_of = TGT_154;
        end else begin
            target_of = TGT_WIFI;
        end
    endfunction

endpackage

@@ sv/wrss_slot_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrss_slot_pick
// Finds the first eligible slot at or after a start slot, wrapping around.
// A slot is eligible when its weight is nonzero and its radio is present.
// ----------------------------------------------------------------------------
module wrss_slot_pick (
    input  wrss_pkg::t_cfg                  i_cfg,
    input  logic [wrss_pkg::SLOT_W-1:0]     i_first,
    output logic                            o_found,
    output logic [wrss_pkg::SLOT_W-1:0]     o_slot
);

    logic [wrss_pkg::NUM_SLOTS-1:0] w_elig;

    // Per-slot eligibility
    always_comb begin
        for (int s = 0; s < wrss_pkg::NUM_SLOTS; s++) begin
            w_elig[s] = (wrss_pkg::weight_of(i_cfg.profile, wrss_pkg::SLOT_W'(s)) != '0)
                        && !((wrss_pkg::SLOT_W'(s) == wrss_pkg::SLOT_154)
                             && !i_cfg.has_154_radio);
        end
    end

    // Rotating search, nearest to the start slot wins
    always_comb begin
        logic [wrss_pkg::SLOT_W-1:0] v_s;
        o_found = 1'b0;
        o_slot  = i_first;
        for (int k = wrss_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            v_s = i_first + wrss_pkg::SLOT_W'(k);
            if (w_elig[v_s]) begin
                o_found = 1'b1;
                o_slot  = v_s;
            end
        end
    end

endmodule

@@ sv/wrss_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrss_core
// Scheduler state (phase, slot, remaining time, survey lock) and the
// single-pass next-state logic for one transaction.
// ----------------------------------------------------------------------------
module wrss_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  wrss_pkg::t_cfg      i_cfg,
    input  wrss_pkg::t_item     i_item,
    output wrss_pkg::t_result   o_result
);

    logic [1:0]                      r_phase, n_phase;
    logic [wrss_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [wrss_pkg::MS_W-1:0]       r_rem, n_rem;
    logic                            r_lock, n_lock;

    logic [wrss_pkg::SLOT_W-1:0]     w_first;
    logic                            w_found;
    logic [wrss_pkg::SLOT_W-1:0]     w_pick;
    logic [wrss_pkg::WEIGHT_W-1:0]   w_weight;
    logic [wrss_pkg::MS_W-1:0]       w_prod;
    logic [wrss_pkg::MS_W-1:0]       w_dwell;
    logic [wrss_pkg::MS_W-1:0]       w_rem_dec;

    // Search starts at slot zero from idle, else after the current slot
    assign w_first = (r_phase == wrss_pkg::PH_IDLE) ? '0
                                                    : r_slot + wrss_pkg::SLOT_W'(1);

    wrss_slot_pick u_pick (
        .i_cfg   (i_cfg),
        .i_first (w_first),
        .o_found (w_found),
        .o_slot  (w_pick)
    );

    // Dwell of the current slot, floored for nonzero weight
    assign w_weight = wrss_pkg::weight_of(i_cfg.profile, r_slot);
    assign w_prod   = wrss_pkg::MS_W'(w_weight) * wrss_pkg::MS_W'(i_cfg.ms_per_weight);
    assign w_dwell  = ((w_weight != '0) && (w_prod < i_cfg.min_dwell_ms))
                      ? i_cfg.min_dwell_ms : w_prod;

    // Tick countdown
    assign w_rem_dec = (i_item.tick && (r_rem != '0))
                       ? r_rem - wrss_pkg::MS_W'(1) : r_rem;

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_slot   = r_slot;
        n_rem    = r_rem;
        n_lock   = r_lock;
        o_result = '0;

        if (i_item.stop_request) begin
            if (r_phase != wrss_pkg::PH_IDLE) begin
                n_phase = wrss_pkg::PH_IDLE;
                n_rem   = '0;
                n_lock  = 1'b0;
                o_result.radio_request_valid = 1'b1;
                o_result.radio_target        = wrss_pkg::TGT_IDLE;
            end
        end else if (r_phase == wrss_pkg::PH_IDLE) begin
            if (i_item.start_request && wrss_pkg::profile_ok(i_cfg.profile)) begin
                n_lock = 1'b1;
                n_slot = '0;
                n_rem  = '0;
                if (w_found) begin
                    n_slot  = w_pick;
                    n_phase = wrss_pkg::PH_AWAIT;
                    o_result.radio_request_valid = 1'b1;
                    o_result.radio_target        = wrss_pkg::target_of(w_pick);
                end else begin
                    n_phase = wrss_pkg::PH_DWELL;
                end
            end
        end else begin
            o_result.start_refused = i_item.start_request;
            if (r_phase == wrss_pkg::PH_AWAIT) begin
                if (i_item.switch_done) begin
                    if (i_item.switch_ok) begin
                        n_phase = wrss_pkg::PH_DWELL;
                        n_rem   = w_dwell;
                    end else begin
                        n_phase = wrss_pkg::PH_PAUSE;
                        n_rem   = i_cfg.fail_pause_ms;
                    end
                end
            end else begin
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    if (w_found) begin
                        n_slot  = w_pick;
                        n_phase = wrss_pkg::PH_AWAIT;
                        o_result.radio_request_valid = 1'b1;
                        o_result.radio_target        = wrss_pkg::target_of(w_pick);
                    end else begin
                        n_phase = wrss_pkg::PH_DWELL;
                        n_rem   = '0;
                    end
                end
            end
        end

        o_result.survey_active = n_lock;
        o_result.current_slot  = n_slot;
        o_result.phase         = n_phase;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wrss_pkg::PH_IDLE;
            r_slot  <= '0;
            r_rem   <= '0;
            r_lock  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_rem   <= n_rem;
            r_lock  <= n_lock;
        end
    end

endmodule

@@ sv/weighted_radio_slot_scheduler.sv @@
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register is written, with the state
// update, into the result register when the output side is free.
// Throughput: one transaction per cycle while the output side is not stalled; the
// input register feeds the state update and result register directly, and the
// result register is emptied whenever the output side is not stalled.
// Reset: synchronous, active low; phase idle, slot 0, lock clear, config to
// defaults (profile 0, 802.15.4 present, 100 ms/weight, 500 ms min, 200 ms pause).
// ----------------------------------------------------------------------------
// weighted_radio_slot_scheduler
// Top level: config registers, input register, scheduler core and result
// register with valid/stall handshakes on both sides.
// ----------------------------------------------------------------------------
module weighted_radio_slot_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Config write port
    input  logic                                i_cfg_we,
    input  logic [wrss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wrss_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_tick,
    input  logic                                i_start_request,
    input  logic                                i_stop_request,
    input  logic                                i_switch_done,
    input  logic                                i_switch_ok,

    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_survey_active,
    output logic [wrss_pkg::SLOT_W-1:0]         o_current_slot,
    output logic                                o_radio_request_valid,
    output logic [1:0]                          o_radio_target,
    output logic                                o_start_refused,
    output logic [1:0]                          o_phase
);

    wrss_pkg::t_cfg     r_cfg;
    logic               r_in_valid;
    wrss_pkg::t_item    r_item;
    logic               r_out_valid;
    wrss_pkg::t_result  r_res;
    wrss_pkg::t_result  w_res;
    logic               w_out_free;
    logic               w_fire;
    logic               w_in_take;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.profile       <= wrss_pkg::RST_PROFILE;
            r_cfg.has_154_radio <= wrss_pkg::RST_HAS_154;
            r_cfg.ms_per_weight <= wrss_pkg::RST_MS_PER_W;
            r_cfg.min_dwell_ms  <= wrss_pkg::RST_MIN_DWELL;
            r_cfg.fail_pause_ms <= wrss_pkg::RST_FAIL_PAUSE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wrss_pkg::CFG_PROFILE:
                    r_cfg.profile <= i_cfg_data[wrss_pkg::PROF_W-1:0];
                wrss_pkg::CFG_HAS_154:
                    r_cfg.has_154_radio <= i_cfg_data[0];
                wrss_pkg::CFG_MS_PER_W:
                    r_cfg.ms_per_weight <= i_cfg_data[wrss_pkg::MSPW_W-1:0];
                wrss_pkg::CFG_MIN_DWELL:
                    r_cfg.min_dwell_ms <= i_cfg_data[wrss_pkg::MS_W-1:0];
                wrss_pkg::CFG_FAIL_PAUSE:
                    r_cfg.fail_pause_ms <= i_cfg_data[wrss_pkg::MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.tick          <= i_tick;
            r_item.start_request <= i_start_request;
            r_item.stop_request  <= i_stop_request;
            r_item.switch_done   <= i_switch_done;
            r_item.switch_ok     <= i_switch_ok;
        end
    end

    wrss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_result (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_survey_active       = r_res.survey_active;
    assign o_current_slot        = r_res.current_slot;
    assign o_radio_request_valid = r_res.radio_request_valid;
    assign o_radio_target        = r_res.radio_target;
    assign o_start_refused       = r_res.start_refused;
    assign o_phase               = r_res.phase;

endmodule
